@@ rtl/array_list_insert_delete_find_assert.svh @@
// Assertion helpers for the list block: clock i_clk, synchronous reset i_rst_n.
`ifndef ARRAY_LIST_INSERT_DELETE_FIND_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_FIND_ASSERT_SVH

// Same-cycle implication.
`define ALI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ali_pkg.sv @@
`default_nettype none

package ali_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP      = 8;
    localparam int OFF_W    = $clog2(GRP);
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [POS_W-1:0]   position;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         found_index;
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
    } t_out_item;

    // Broadcast to every cell.
    typedef struct packed {
        logic             do_ins;
        logic             do_del;
        logic             do_wr;
        logic             do_find;
        logic             do_read;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [31:0]      key;
    } t_cell_ctl;

    // Lowest hit of one group of cells.
    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] off;
        logic [31:0]      value;
    } t_grp_res;

endpackage

`default_nettype wire

@@ rtl/array_list_insert_delete_find.sv @@
// A transaction passes the cell registers, the group select registers and the final select
// into the output register. No new transaction is taken while one is in the row or select tree.
// A new transaction is taken while a finished result still waits on the output register.
// Reset (i_rst_n low, synchronous) empties the list and clears all pipeline valids;
// list contents are not cleared and are never returned before being written.
`default_nettype none

module array_list_insert_delete_find (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ali_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ali_pkg::t_out_item o_item
);
    import ali_pkg::*;

    // Control and bookkeeping
    logic             w_accept;
    logic             w_load_out;
    logic [2:0]       w_status;
    logic             w_ok;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic [CMP_W-1:0] w_cap_x;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_s1_v;   // cells hold hit flags
    logic             r_s2_v;   // group registers hold partial selects
    logic             r_out_v;
    logic [2:0]       r_cmd;
    logic [2:0]       r_status;
    t_out_item        r_out;
    t_out_item        n_out;

    t_cell_ctl        w_ctl;

    // Cell row and select tree
    logic [31:0]      w_value [CAPACITY];
    logic             w_hit   [NGRP*GRP];
    logic [31:0]      w_hval  [NGRP*GRP];
    t_grp_res         w_grp   [NGRP];

    logic             w_any;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_sel;

    assign o_ready    = !r_s1_v && !r_s2_v;
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = r_s2_v && (!r_out_v || i_ready);

    // Status checks on the incoming command, against the current count.
    assign w_pos_x = CMP_W'(i_item.position);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_cap_x = CMP_W'(CAPACITY);

    always_comb begin
        w_status = ST_OK;
        case (i_item.command)
            CMD_INSERT: begin
                // full wins over a bad position
                if (w_cnt_x >= w_cap_x) begin
                    w_status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end
            end
            CMD_DELETE, CMD_WRITE, CMD_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end
            end
            default: w_status = ST_OK;  // find resolves later; unused codes do nothing
        endcase
    end

    assign w_ok = (w_status == ST_OK);

    // Broadcast to the row. Position fits CNT_W whenever the command is legal.
    always_comb begin
        w_ctl         = '0;
        w_ctl.do_ins  = w_accept && w_ok && (i_item.command == CMD_INSERT);
        w_ctl.do_del  = w_accept && w_ok && (i_item.command == CMD_DELETE);
        w_ctl.do_wr   = w_accept && w_ok && (i_item.command == CMD_WRITE);
        w_ctl.do_find = w_accept && (i_item.command == CMD_FIND);
        w_ctl.do_read = w_accept && w_ok && (i_item.command == CMD_READ);
        w_ctl.pos     = CNT_W'(i_item.position);
        w_ctl.count   = r_count;
        w_ctl.key     = i_item.operand_value;
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.do_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Cell row: each slot talks to its two neighbors only.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [31:0] w_prev;
        logic [31:0] w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_value[gi];
        end else begin : g_mid_p
            assign w_prev = w_value[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = w_value[gi];
        end else begin : g_mid_n
            assign w_next = w_value[gi+1];
        end

        ali_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (CNT_W'(gi)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_value[gi]),
            .o_hit   (w_hit[gi])
        );

        assign w_hval[gi] = w_value[gi];
    end

    // Pad the last group when the capacity is not a multiple of the group size.
    for (genvar gp = CAPACITY; gp < NGRP*GRP; gp++) begin : g_pad
        assign w_hit[gp]  = 1'b0;
        assign w_hval[gp] = '0;
    end

    // First select level: lowest hit inside each group, loaded while hits are fresh.
    for (genvar gg = 0; gg < NGRP; gg++) begin : g_grp
        ali_group u_group (
            .i_clk   (i_clk),
            .i_en    (r_s1_v),
            .i_hit   (w_hit[gg*GRP +: GRP]),
            .i_value (w_hval[gg*GRP +: GRP]),
            .o_res   (w_grp[gg])
        );
    end

    // Second select level: lowest group with a hit.
    always_comb begin
        w_any = 1'b0;
        w_idx = '0;
        w_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_grp[g].hit) begin
                w_any = 1'b1;
                w_idx = IDX_W'(g*GRP + int'(w_grp[g].off));
                w_sel = w_grp[g].value;
            end
        end
    end

    // Result assembly; r_cmd, r_status and r_count still belong to this transaction.
    always_comb begin
        n_out             = '0;
        n_out.status      = r_status;
        n_out.entry_count = 7'(r_count);
        if (r_cmd == CMD_FIND) begin
            n_out.status = w_any ? ST_OK : ST_NOTFOUND;
            if (w_any) begin
                n_out.found_index = 6'(w_idx);
            end
        end else if (r_cmd == CMD_READ && r_status == ST_OK) begin
            n_out.read_value = w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_count <= n_count;
            r_s1_v  <= w_accept;
            if (r_s1_v) begin
                r_s2_v <= 1'b1;
            end else if (w_load_out) begin
                r_s2_v <= 1'b0;
            end
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_item.command;
            r_status <= w_status;
        end
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    `include "array_list_insert_delete_find_assert.svh"

    `ALI_ASSERT_NOW(a_one_in_flight, 1'b1, !(r_s1_v && r_s2_v), "two commands in the select tree")
    `ALI_ASSERT_NEXT(a_accept_starts, w_accept, r_s1_v, "accepted command did not enter the row")
    `ALI_ASSERT_NEXT(a_count_quiet, !w_accept, $stable(r_count), "count moved without a command")
    `ALI_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(CAPACITY), "count beyond capacity")

endmodule

`default_nettype wire

@@ rtl/ali_cell.sv @@
`default_nettype none

// One list slot: shifts with its neighbors, flags a key or position hit.
module ali_cell (
    input  logic                      i_clk,
    input  ali_pkg::t_cell_ctl        i_ctl,
    input  logic [ali_pkg::CNT_W-1:0] i_idx,
    input  logic [31:0]               i_prev,
    input  logic [31:0]               i_next,
    output logic [31:0]               o_value,
    output logic                      o_hit
);
    import ali_pkg::*;

    logic [31:0] r_value;
    logic [31:0] n_value;
    logic        r_hit;
    logic        n_hit;

    always_comb begin
        n_value = r_value;
        if (i_ctl.do_ins) begin
            if (i_idx == i_ctl.pos) begin
                n_value = i_ctl.key;
            end else if (i_idx > i_ctl.pos && i_idx <= i_ctl.count) begin
                n_value = i_prev;
            end
        end else if (i_ctl.do_del) begin
            if (i_idx >= i_ctl.pos) begin
                n_value = i_next;
            end
        end else if (i_ctl.do_wr) begin
            if (i_idx == i_ctl.pos) begin
                n_value = i_ctl.key;
            end
        end
        n_hit = (i_ctl.do_find && (i_idx < i_ctl.count) && (r_value == i_ctl.key)) ||
                (i_ctl.do_read && (i_idx == i_ctl.pos));
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hit   <= n_hit;
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

@@ rtl/ali_group.sv @@
`default_nettype none

// Lowest-hit select over one group of cells, registered.
module ali_group (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_hit   [ali_pkg::GRP],
    input  logic [31:0]        i_value [ali_pkg::GRP],
    output ali_pkg::t_grp_res  o_res
);
    import ali_pkg::*;

    t_grp_res r_res;
    t_grp_res n_res;

    always_comb begin
        n_res = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                n_res.hit   = 1'b1;
                n_res.off   = OFF_W'(k);
                n_res.value = i_value[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

@@ tb/array_list_insert_delete_find_tb.sv @@
`timescale 1ns / 1ps

module array_list_insert_delete_find_tb;
    import ali_pkg::*;

    // Back-pressure profile, carried by each queued transaction so that the
    // driver and the monitor switch profile at the same point in the stream.
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    // One queued stimulus entry. A hold entry makes the driver wait until
    // every outstanding result has come back before it sends anything more.
    typedef struct packed {
        logic       hold;
        t_idle_mode mode;
        t_in_item   item;
    } t_stim;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction at all
    localparam int TAIL_CYCLES    = 8;      // margin after the last result is back
    localparam int PHASE_ITEMS    = 250;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    array_list_insert_delete_find dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // List model: contents and length as the block should hold them.
    // Only updated when a command transaction is accepted.
    // ------------------------------------------------------------------
    logic signed [31:0] list_val [CAPACITY];
    int                 list_len = 0;

    t_stim      stim_q [$];     // transactions not yet sent
    t_out_item  pred_q [$];     // expected results, oldest first
    t_idle_mode sink_mode = IDLE_NONE;
    int         mismatches = 0;
    int         idle_cycles = 0;

    // Apply one command to the list model and return the result it gives.
    function automatic t_out_item apply_command(input t_in_item cmd);
        t_out_item r;
        int        pos;
        int        i;
        r   = '0;
        pos = cmd.position;
        case (cmd.command)
            CMD_INSERT: begin
                // full test wins over the position test
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > pos; i--)
                        list_val[i] = list_val[i-1];
                    list_val[pos] = cmd.operand_value;
                    list_len++;
                end
            end
            CMD_DELETE, CMD_WRITE, CMD_READ: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else if (cmd.command == CMD_DELETE) begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_val[i] = list_val[i+1];
                    list_len--;
                end else if (cmd.command == CMD_WRITE) begin
                    list_val[pos] = cmd.operand_value;
                end else begin
                    r.read_value = list_val[pos];
                end
            end
            CMD_FIND: begin
                // scan downward so the last hit kept is the lowest index
                r.status = ST_NOTFOUND;
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_val[i] == cmd.operand_value) begin
                        r.status      = ST_OK;
                        r.found_index = i[5:0];
                    end
                end
            end
            default: ;  // unused codes: no change, status ok
        endcase
        r.entry_count = list_len[6:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders. gen_len tracks only the list length, so the random
    // part can steer positions toward legal ones and swing between empty
    // and full.
    // ------------------------------------------------------------------
    int                 gen_len = 0;
    t_idle_mode         gen_mode = IDLE_NONE;
    logic signed [31:0] value_pool [8];

    task automatic queue_cmd(input logic [2:0] code, input int pos,
                             input logic [31:0] value);
        t_stim s;
        s.hold               = 1'b0;
        s.mode               = gen_mode;
        s.item.command       = code;
        s.item.position      = pos[6:0];
        s.item.operand_value = value;
        stim_q.push_back(s);
        if (code == CMD_INSERT && gen_len < CAPACITY && pos <= gen_len)
            gen_len++;
        else if (code == CMD_DELETE && gen_len > 0 && pos < gen_len)
            gen_len--;
    endtask

    task automatic queue_hold();
        t_stim s;
        s      = '0;
        s.hold = 1'b1;
        s.mode = gen_mode;
        stim_q.push_back(s);
    endtask

    // Mostly legal positions with the ends favored; some fully random.
    function automatic int pick_pos(input int hi);
        int r;
        r = $urandom_range(99);
        if (hi < 0 || r < 8)
            return $urandom_range(127);
        if (r < 18)
            return 0;
        if (r < 28)
            return hi;
        return $urandom_range(hi, 0);
    endfunction

    // Pool values repeat often, so finds hit and duplicates pile up.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 65)
            return value_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    initial begin
        int   ph;
        int   roll;
        int   ins_cut;
        int   del_cut;
        logic growing;

        // Directed: empty-list errors, ends of the position and value
        // ranges, prepend / middle / append, duplicates, misses, unused codes.
        queue_cmd(CMD_DELETE, 0, 32'd0);
        queue_cmd(CMD_READ,   0, 32'd0);
        queue_cmd(CMD_WRITE,  0, 32'd5);
        queue_cmd(CMD_FIND,   0, 32'd0);                 // miss on empty list
        queue_cmd(CMD_INSERT, 1, 32'd1);                 // beyond count
        queue_cmd(CMD_INSERT, 127, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 0, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 1, 32'h7FFF_FFFF);         // append
        queue_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);         // prepend
        queue_cmd(CMD_INSERT, 2, 32'd0);                 // middle
        queue_cmd(CMD_INSERT, 4, 32'hFFFF_FFFF);         // duplicate at tail
        queue_cmd(CMD_FIND,   99, 32'hFFFF_FFFF);        // lowest of two hits
        queue_cmd(CMD_FIND,   0, 32'd0);
        queue_cmd(CMD_FIND,   0, 32'd12345);             // miss
        queue_cmd(CMD_READ,   4, 32'd0);
        queue_cmd(CMD_READ,   5, 32'd0);                 // at count
        queue_cmd(CMD_WRITE,  1, 32'h5A5A_A5A5);
        queue_cmd(CMD_READ,   1, 32'd0);
        queue_cmd(CMD_WRITE,  5, 32'd7);                 // at count
        queue_cmd(CMD_DELETE, 0, 32'd0);
        queue_cmd(CMD_DELETE, 3, 32'd0);                 // last entry
        queue_cmd(CMD_DELETE, 3, 32'd0);                 // now at count
        queue_cmd(3'd7, 127, 32'hFFFF_FFFF);             // unused code
        queue_cmd(3'd5, 0, 32'd0);
        queue_cmd(CMD_FIND,   0, 32'h7FFF_FFFF);

        value_pool[0] = 32'sd0;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        growing = 1'b1;

        // Random part: one block of transactions per idle profile, with a
        // full drain in front of each. Grow toward full, shrink toward
        // empty, and linger at each end so full and empty errors show up.
        for (ph = 0; ph < 4; ph++) begin
            gen_mode = t_idle_mode'(ph);
            queue_hold();
            for (int k = 4; k < 8; k++)
                value_pool[k] = $urandom();
            repeat (PHASE_ITEMS) begin
                roll    = $urandom_range(99);
                ins_cut = growing ? 55 : 15;
                del_cut = ins_cut + (growing ? 15 : 55);
                if (roll < ins_cut)
                    queue_cmd(CMD_INSERT, pick_pos(gen_len), pick_value());
                else if (roll < del_cut)
                    queue_cmd(CMD_DELETE, pick_pos(gen_len - 1), pick_value());
                else if (roll < del_cut + 10)
                    queue_cmd(CMD_FIND, $urandom_range(127), pick_value());
                else if (roll < del_cut + 18)
                    queue_cmd(CMD_WRITE, pick_pos(gen_len - 1), pick_value());
                else if (roll < del_cut + 27)
                    queue_cmd(CMD_READ, pick_pos(gen_len - 1), pick_value());
                else
                    queue_cmd(3'($urandom_range(7, 5)), $urandom_range(127), $urandom());
                if (growing && gen_len == CAPACITY && $urandom_range(9) < 2)
                    growing = 1'b0;
                else if (!growing && gen_len == 0 && $urandom_range(9) < 3)
                    growing = 1'b1;
            end
        end

        // Single reset at start of run.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Checked away from the rising edge, once the driver and monitor
        // have settled: last command out, then its result back.
        while (stim_q.size() != 0 || i_valid || pred_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued commands, holds each until accepted, and
    // runs the list model on every accepted transaction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic  took;
        logic  send;
        logic  gap;
        t_stim head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && o_ready;
            if (took)
                pred_q.push_back(apply_command(i_item));
            // only move on when nothing is waiting on the input channel
            if (!i_valid || took) begin
                send = 1'b0;
                if (stim_q.size() != 0) begin
                    if (stim_q[0].hold) begin
                        // sender pause: release once all results are back
                        if (pred_q.size() == 0)
                            head = stim_q.pop_front();
                    end else begin
                        roll_gap(stim_q[0].mode, gap);
                        if (!gap) begin
                            head      = stim_q.pop_front();
                            i_item    <= head.item;
                            sink_mode <= head.mode;
                            send      = 1'b1;
                        end
                    end
                end
                i_valid <= send;
            end
        end
    end

    task automatic roll_gap(input t_idle_mode mode, output logic gap);
        gap = (mode == IDLE_SRC  && $urandom_range(99) < 53) ||
              (mode == IDLE_BOTH && $urandom_range(99) < 24);
    endtask

    // ------------------------------------------------------------------
    // Monitor: random stalls on the result channel, and every accepted
    // result checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        logic      stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pred_q.size() == 0) begin
                    $error("result with no command outstanding: %p", o_item);
                    mismatches++;
                end else begin
                    want = pred_q.pop_front();
                    check_field("status",      want.status,      o_item.status);
                    check_field("found_index", want.found_index, o_item.found_index);
                    check_field("read_value",  want.read_value,  o_item.read_value);
                    check_field("entry_count", want.entry_count, o_item.entry_count);
                end
            end
            stall = (sink_mode == IDLE_SINK && $urandom_range(99) < 53) ||
                    (sink_mode == IDLE_BOTH && $urandom_range(99) < 24);
            i_ready <= !stall;
        end
    end

    // Watchdog: too long without a transaction on either channel means
    // the block is hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ali_pkg.sv
rtl/ali_cell.sv
rtl/ali_group.sv
rtl/array_list_insert_delete_find.sv
tb/array_list_insert_delete_find_tb.sv
